>>> design/ltcc_pkg.sv
`default_nettype none

package ltcc_pkg;

  // Configuration register file
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned CAP_W      = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Register index, taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  // Fixed field widths of the stream items
  localparam int unsigned KEY_FIELD_W  = 16;
  localparam int unsigned SLOT_FIELD_W = 4;
  localparam int unsigned OUT_DATA_W   = 24;

  // Input opcodes
  localparam logic OPC_LOOKUP = 1'b0;
  localparam logic OPC_CLEAR  = 1'b1;

  // What one processed item does to the stored entries
  typedef enum logic [2:0] {
    UPD_NONE  = 3'd0,
    UPD_CLEAR = 3'd1,
    UPD_HIT   = 3'd2,
    UPD_FILL  = 3'd3,
    UPD_EVICT = 3'd4
  } upd_e;

endpackage

`default_nettype wire

>>> design/lru_tag_cache_controller_unit.sv
// Fully associative tag cache with least-recently-used replacement. Each input
// item is a lookup of a key (tuser 0) or a clear of all entries (tuser 1), and
// yields exactly one result item: hit flag, slot that now holds the key (on a
// miss the slot to fill), an evicted flag and the displaced key. A miss fills
// the lowest free slot while fewer entries than the capacity register are held,
// otherwise it reuses the slot of the least recent entry. The block accepts one
// item per clock cycle while the result side does not stall: an item passes the
// input register, then the tag compare, victim choice and rank update of all
// slots, combinationally, into the result register. The low five bits of the
// capacity register (address 0) read back as written; zero acts as one and
// values above NUM_SLOTS act as NUM_SLOTS. Clear the store after lowering it.
`default_nettype none

module lru_tag_cache_controller_unit #(
  parameter int unsigned NUM_SLOTS = 16,
  parameter int unsigned KEY_WIDTH = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // s_axis_tdata_i: [15:0] key
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  wire logic [15:0]                     s_axis_tdata_i,
  // s_axis_tuser_i: [0] opcode
  input  wire logic [0:0]                      s_axis_tuser_i,
  // m_axis_tdata_o: [0] hit, [4:1] slot, [5] evicted, [21:6] evicted_key, [23:22] zero
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  output logic      [ltcc_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ltcc_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [ltcc_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [ltcc_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready
);
  import ltcc_pkg::*;

  localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CW = $clog2(NUM_SLOTS+1);
  localparam int unsigned MW = (CW > CAP_W) ? CW : CAP_W;

  logic [CAP_W-1:0]       capacity;

  logic                   in_valid_q;
  logic                   in_op_q;
  logic [KEY_FIELD_W-1:0] in_key_q;
  logic                   fire;

  logic [KEY_WIDTH+KEY_FIELD_W-1:0] key_ext;
  logic [KEY_WIDTH-1:0]   key_tag;

  logic [NUM_SLOTS-1:0]   valid;
  logic [NUM_SLOTS-1:0]   match;
  logic [NUM_SLOTS-1:0]   victim;
  logic [KEY_WIDTH-1:0]   victim_tag;
  logic [CW-1:0]          count;

  logic [NUM_SLOTS-1:0]   hit_sel;
  logic [NUM_SLOTS-1:0]   free_sel;
  logic [MW-1:0]          cap_ext;
  logic [MW-1:0]          eff_cap;
  logic                   room;

  upd_e                   upd_kind;
  upd_e                   upd;
  logic [NUM_SLOTS-1:0]   sel;
  logic [IW-1:0]          pos;
  logic [IW+SLOT_FIELD_W-1:0]       pos_ext;
  logic [KEY_WIDTH+KEY_FIELD_W-1:0] ev_ext;

  logic                    res_hit, res_evicted;
  logic [SLOT_FIELD_W-1:0] res_slot;
  logic [KEY_FIELD_W-1:0]  res_ev_key;

  logic                    out_valid_q, out_valid_d;
  logic                    out_hit_q, out_evicted_q;
  logic [SLOT_FIELD_W-1:0] out_slot_q;
  logic [KEY_FIELD_W-1:0]  out_ev_key_q;

  ltcc_apb_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .capacity_o (capacity)
  );

  // Input register
  assign fire            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_op_q  <= s_axis_tuser_i[0];
      in_key_q <= s_axis_tdata_i;
    end
  end

  // Keep only the low KEY_WIDTH bits of the key
  assign key_ext = {{KEY_WIDTH{1'b0}}, in_key_q};
  assign key_tag = key_ext[KEY_WIDTH-1:0];

  ltcc_tag_store #(
    .NUM_SLOTS (NUM_SLOTS),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_tags (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (upd),
    .sel_i    (sel),
    .key_i    (key_tag),
    .rd_sel_i (victim),
    .valid_o  (valid),
    .match_o  (match),
    .rd_tag_o (victim_tag)
  );

  ltcc_recency #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_recency (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (upd),
    .sel_i    (sel),
    .valid_i  (valid),
    .victim_o (victim),
    .count_o  (count)
  );

  // Lowest set bit of match, lowest clear bit of valid
  assign hit_sel  = match & (~match + NUM_SLOTS'(1));
  assign free_sel = ~valid & (valid + NUM_SLOTS'(1));

  assign cap_ext = MW'(capacity);
  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = MW'(1);
    end else if (cap_ext > MW'(NUM_SLOTS)) begin
      eff_cap = MW'(NUM_SLOTS);
    end else begin
      eff_cap = cap_ext;
    end
  end
  assign room = MW'(count) < eff_cap;

  always_comb begin
    priority if (in_op_q == OPC_CLEAR) begin
      upd_kind = UPD_CLEAR;
      sel      = '0;
    end else if (|match) begin
      upd_kind = UPD_HIT;
      sel      = hit_sel;
    end else if (room) begin
      upd_kind = UPD_FILL;
      sel      = free_sel;
    end else begin
      upd_kind = UPD_EVICT;
      sel      = victim;
    end
  end

  assign upd = fire ? upd_kind : UPD_NONE;

  always_comb begin
    pos = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (sel[i]) begin
        pos = pos | IW'(i);
      end
    end
  end

  assign pos_ext     = {{SLOT_FIELD_W{1'b0}}, pos};
  assign ev_ext      = {{KEY_FIELD_W{1'b0}}, victim_tag};
  assign res_hit     = (upd_kind == UPD_HIT);
  assign res_evicted = (upd_kind == UPD_EVICT);
  assign res_slot    = (upd_kind == UPD_CLEAR) ? '0 : pos_ext[SLOT_FIELD_W-1:0];
  assign res_ev_key  = res_evicted ? ev_ext[KEY_FIELD_W-1:0] : '0;

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_hit_q     <= res_hit;
      out_evicted_q <= res_evicted;
      out_slot_q    <= res_slot;
      out_ev_key_q  <= res_ev_key;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_ev_key_q, out_evicted_q, out_slot_q, out_hit_q};

  // Entry count tracks the valid bits
  a_count_matches_valid: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $countones(valid) == int'(count)
  ) else $error("entry count differs from number of valid entries");

  // A lookup touches exactly one slot
  a_lookup_onehot: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (fire && (upd_kind != UPD_CLEAR)) |-> $onehot(sel)
  ) else $error("lookup does not select exactly one slot");

  // A clear leaves no valid entry behind
  a_clear_empties: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (fire && (upd_kind == UPD_CLEAR)) |=> (valid == '0) && (count == '0)
  ) else $error("entries remain valid after clear");

  // A result is never both a hit and an eviction
  a_hit_excl_evict: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_hit_q && out_evicted_q)
  ) else $error("result flags hit and eviction together");

endmodule

`default_nettype wire

>>> design/ltcc_apb_regs.sv
`default_nettype none

module ltcc_apb_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ltcc_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [ltcc_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [ltcc_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready,
  output logic      [ltcc_pkg::CAP_W-1:0]      capacity_o
);
  import ltcc_pkg::*;

  logic [CAP_W-1:0] capacity_q, capacity_d;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);

  always_comb begin
    capacity_d = capacity_q;
    if (wr_en) begin
      capacity_d = pwdata[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else begin
      capacity_q <= capacity_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CAPACITY) begin
      prdata = {{(APB_DATA_W-CAP_W){1'b0}}, capacity_q};
    end
  end

  assign capacity_o = capacity_q;

endmodule

`default_nettype wire

>>> design/ltcc_tag_store.sv
`default_nettype none

module ltcc_tag_store #(
  parameter int unsigned NUM_SLOTS = 16,
  parameter int unsigned KEY_WIDTH = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ltcc_pkg::upd_e        upd_i,
  input  wire logic [NUM_SLOTS-1:0]  sel_i,
  input  wire logic [KEY_WIDTH-1:0]  key_i,
  input  wire logic [NUM_SLOTS-1:0]  rd_sel_i,
  output logic      [NUM_SLOTS-1:0]  valid_o,
  output logic      [NUM_SLOTS-1:0]  match_o,
  output logic      [KEY_WIDTH-1:0]  rd_tag_o
);
  import ltcc_pkg::*;

  logic [KEY_WIDTH-1:0] tag_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] valid_q, valid_d;
  logic                 tag_we;

  assign tag_we = (upd_i == UPD_FILL) || (upd_i == UPD_EVICT);

  always_comb begin
    valid_d = valid_q;
    if (upd_i == UPD_CLEAR) begin
      valid_d = '0;
    end else if (upd_i == UPD_FILL) begin
      valid_d = valid_q | sel_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Tags are payload: only entries with a valid bit are ever looked at
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (tag_we && sel_i[i]) begin
        tag_q[i] <= key_i;
      end
    end
  end

  always_comb begin
    rd_tag_o = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      match_o[i] = valid_q[i] && (tag_q[i] == key_i);
      if (rd_sel_i[i]) begin
        rd_tag_o = rd_tag_o | tag_q[i];
      end
    end
  end

  assign valid_o = valid_q;

endmodule

`default_nettype wire

>>> design/ltcc_recency.sv
`default_nettype none

module ltcc_recency #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ltcc_pkg::upd_e                upd_i,
  input  wire logic [NUM_SLOTS-1:0]          sel_i,
  input  wire logic [NUM_SLOTS-1:0]          valid_i,
  output logic      [NUM_SLOTS-1:0]          victim_o,
  output logic      [$clog2(NUM_SLOTS+1)-1:0] count_o
);
  import ltcc_pkg::*;

  localparam int unsigned RW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CW = $clog2(NUM_SLOTS+1);

  logic [RW-1:0]        rank_q [NUM_SLOTS];
  logic [RW-1:0]        rank_d [NUM_SLOTS];
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        count_m1;
  logic [RW-1:0]        sel_rank;
  logic [NUM_SLOTS-1:0] oldest;

  // Valid ranks always form 0 .. count-1, so the oldest entry is rank count-1
  assign count_m1 = count_q - CW'(1);

  always_comb begin
    sel_rank = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      oldest[i] = valid_i[i] && (rank_q[i] == count_m1[RW-1:0]);
      if (sel_i[i]) begin
        sel_rank = sel_rank | rank_q[i];
      end
    end
  end

  assign victim_o = oldest & (~oldest + NUM_SLOTS'(1));

  always_comb begin
    count_d = count_q;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      rank_d[i] = rank_q[i];
    end
    unique case (upd_i)
      UPD_CLEAR: begin
        count_d = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          rank_d[i] = '0;
        end
      end
      UPD_FILL: begin
        count_d = count_q + CW'(1);
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (sel_i[i]) begin
            rank_d[i] = '0;
          end else if (valid_i[i]) begin
            rank_d[i] = rank_q[i] + RW'(1);
          end
        end
      end
      UPD_HIT, UPD_EVICT: begin
        // age everything more recent than the touched entry
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (sel_i[i]) begin
            rank_d[i] = '0;
          end else if (valid_i[i] && (rank_q[i] < sel_rank)) begin
            rank_d[i] = rank_q[i] + RW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      count_q <= count_d;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  assign count_o = count_q;

endmodule

`default_nettype wire

>>> dv/tb_lru_tag_cache_controller_unit.sv
`default_nettype none

module tb_lru_tag_cache_controller_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ltcc_pkg::*;

  localparam int SLOTS = 16;
  localparam int PHASE_ITEMS = 75;
  localparam logic [APB_ADDR_W-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};

  // Result item as it sits in m_axis_tdata_o, hit in bit 0
  typedef struct packed {
    logic [1:0]  pad;
    logic [15:0] evicted_key;
    logic        evicted;
    logic [3:0]  slot;
    logic        hit;
  } lookup_res_t;

  typedef struct {
    int          cap_write;   // -1: leave the capacity as it is
    logic        op;
    logic [15:0] key;
    bit          pinned;      // result typed in below
    lookup_res_t res;
  } row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [15:0]           s_axis_tdata_i = '0;
  logic [0:0]            s_axis_tuser_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  lru_tag_cache_controller_unit #(
    .NUM_SLOTS(SLOTS),
    .KEY_WIDTH(16)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Mirror of the tag store
  logic [15:0]      cached_tag [SLOTS];
  bit               cached_valid [SLOTS];
  int               cached_rank [SLOTS];
  int               cached_count = 0;
  logic [CAP_W-1:0] cache_capacity = CAP_RESET;

  lookup_res_t pending_results[$];
  bit          pin_valid = 1'b0;
  lookup_res_t pin_res = '0;
  bit          calm = 1'b0;
  int          fail_count = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic lookup_res_t outcome(logic hit, logic [3:0] slot, logic evicted,
                                          logic [15:0] evicted_key);
    lookup_res_t r;
    r = '0;
    r.hit = hit;
    r.slot = slot;
    r.evicted = evicted;
    r.evicted_key = evicted_key;
    return r;
  endfunction

  function automatic void age_ranks(int limit);
    for (int i = 0; i < SLOTS; i++) begin
      if (cached_valid[i] && cached_rank[i] < limit) cached_rank[i]++;
    end
  endfunction

  function automatic lookup_res_t predict_lookup(logic op, logic [15:0] key);
    lookup_res_t r;
    bit          found;
    int          pos;
    int          cap_eff;
    r = '0;
    found = 1'b0;
    pos = 0;
    cap_eff = (cache_capacity == 0) ? 1 : (cache_capacity > SLOTS) ? SLOTS : cache_capacity;
    if (op == OPC_CLEAR) begin
      foreach (cached_valid[i]) begin
        cached_valid[i] = 1'b0;
        cached_rank[i] = 0;
      end
      cached_count = 0;
      return r;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (!found && cached_valid[i] && cached_tag[i] == key) begin
        found = 1'b1;
        pos = i;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      age_ranks(cached_rank[pos]);
      cached_rank[pos] = 0;
    end else if (cached_count < cap_eff) begin
      // fill the lowest free slot
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (!cached_valid[i]) pos = i;
      end
      age_ranks(SLOTS + 1);
      cached_valid[pos] = 1'b1;
      cached_tag[pos] = key;
      cached_rank[pos] = 0;
      cached_count++;
    end else begin
      // evict the oldest entry, lowest slot on a tie
      for (int i = 0; i < SLOTS; i++) begin
        if (cached_valid[i] && (!found || cached_rank[i] > cached_rank[pos])) begin
          found = 1'b1;
          pos = i;
        end
      end
      r.evicted = 1'b1;
      r.evicted_key = cached_tag[pos];
      age_ranks(cached_rank[pos]);
      cached_tag[pos] = key;
      cached_rank[pos] = 0;
    end
    r.slot = pos[3:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    lookup_res_t want;
    lookup_res_t got;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        want = predict_lookup(s_axis_tuser_i[0], s_axis_tdata_i);
        if (pin_valid) want = pin_res;
        pending_results = {pending_results, want};
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = m_axis_tdata_o;
        if (pending_results.size() == 0) begin
          $error("result item with nothing pending: 0x%0h", m_axis_tdata_o);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("hit", 16'(want.hit), 16'(got.hit));
          check_field("slot", 16'(want.slot), 16'(got.slot));
          check_field("evicted", 16'(want.evicted), 16'(got.evicted));
          check_field("evicted_key", want.evicted_key, got.evicted_key);
        end
      end
    end
  end

  // Stall the result side
  always @(negedge clk_i) begin
    m_axis_tready_i <= calm || ($urandom_range(99) >= 13);
  end

  task automatic push_item(logic op, logic [15:0] key);
    while (!calm && $urandom_range(99) < 13) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= op;
    s_axis_tdata_i <= key;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    logic [APB_DATA_W-1:0] word;
    word = $urandom;
    word[CAP_W-1:0] = cap;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAP_ADDR;
    pwdata <= word;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cache_capacity = cap;
    @(negedge clk_i);
    // read back
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== APB_DATA_W'(cap)) begin
      $error("capacity: expected 0x%0h, got 0x%0h", cap, prdata);
      fail_count++;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin : driver
    row_t        directed_rows[22];
    logic [15:0] key_pool[24];
    int          phase_caps[12];
    int          cap;
    int          span;
    int          roll;

    directed_rows = '{
      '{-1, OPC_LOOKUP, 16'h0000, 1'b1, outcome(1'b0, 4'd0, 1'b0, 16'h0000)},
      '{-1, OPC_LOOKUP, 16'hFFFF, 1'b1, outcome(1'b0, 4'd1, 1'b0, 16'h0000)},
      '{-1, OPC_LOOKUP, 16'h0000, 1'b1, outcome(1'b1, 4'd0, 1'b0, 16'h0000)},
      '{-1, OPC_CLEAR,  16'h0000, 1'b1, outcome(1'b0, 4'd0, 1'b0, 16'h0000)},
      '{-1, OPC_LOOKUP, 16'h8001, 1'b1, outcome(1'b0, 4'd0, 1'b0, 16'h0000)},
      '{ 1, OPC_LOOKUP, 16'h5555, 1'b1, outcome(1'b0, 4'd0, 1'b1, 16'h8001)},
      '{-1, OPC_LOOKUP, 16'hAAAA, 1'b1, outcome(1'b0, 4'd0, 1'b1, 16'h5555)},
      '{-1, OPC_LOOKUP, 16'hAAAA, 1'b1, outcome(1'b1, 4'd0, 1'b0, 16'h0000)},
      '{ 0, OPC_LOOKUP, 16'h1234, 1'b1, outcome(1'b0, 4'd0, 1'b1, 16'hAAAA)},
      '{-1, OPC_CLEAR,  16'hFFFF, 1'b1, outcome(1'b0, 4'd0, 1'b0, 16'h0000)},
      '{ 2, OPC_LOOKUP, 16'h0001, 1'b1, outcome(1'b0, 4'd0, 1'b0, 16'h0000)},
      '{-1, OPC_LOOKUP, 16'h0002, 1'b1, outcome(1'b0, 4'd1, 1'b0, 16'h0000)},
      '{-1, OPC_LOOKUP, 16'h0001, 1'b1, outcome(1'b1, 4'd0, 1'b0, 16'h0000)},
      '{-1, OPC_LOOKUP, 16'h0003, 1'b1, outcome(1'b0, 4'd1, 1'b1, 16'h0002)},
      '{-1, OPC_LOOKUP, 16'h0001, 1'b1, outcome(1'b1, 4'd0, 1'b0, 16'h0000)},
      '{31, OPC_LOOKUP, 16'h0004, 1'b1, outcome(1'b0, 4'd2, 1'b0, 16'h0000)},
      // capacity lowered below the count, no clear
      '{ 1, OPC_LOOKUP, 16'h0005, 1'b0, '0},
      '{-1, OPC_LOOKUP, 16'h0006, 1'b0, '0},
      '{-1, OPC_LOOKUP, 16'h0004, 1'b0, '0},
      '{-1, OPC_CLEAR,  16'h0000, 1'b1, outcome(1'b0, 4'd0, 1'b0, 16'h0000)},
      '{16, OPC_LOOKUP, 16'hFFFF, 1'b1, outcome(1'b0, 4'd0, 1'b0, 16'h0000)},
      '{-1, OPC_LOOKUP, 16'hFFFF, 1'b1, outcome(1'b1, 4'd0, 1'b0, 16'h0000)}
    };
    phase_caps = '{4, 16, 1, 31, 0, 8, 2, 16, -1, -1, 3, 12};

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].cap_write >= 0) begin
        wait_drained();
        write_capacity(directed_rows[r].cap_write[CAP_W-1:0]);
      end
      pin_valid = directed_rows[r].pinned;
      pin_res = directed_rows[r].res;
      push_item(directed_rows[r].op, directed_rows[r].key);
    end
    pin_valid = 1'b0;

    foreach (phase_caps[p]) begin
      wait_drained();
      cap = (phase_caps[p] < 0) ? $urandom_range(31) : phase_caps[p];
      write_capacity(cap[CAP_W-1:0]);
      span = ((cap == 0) ? 1 : (cap > SLOTS) ? SLOTS : cap) + 4;
      foreach (key_pool[j]) key_pool[j] = 16'($urandom);
      calm = (p == 7);
      // sometimes keep the old entries across a capacity change
      if ($urandom_range(1) == 1) push_item(OPC_CLEAR, 16'($urandom));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        roll = $urandom_range(99);
        if (roll < 3) begin
          push_item(OPC_CLEAR, 16'($urandom));
        end else if (roll < 20) begin
          push_item(OPC_LOOKUP, 16'($urandom));
        end else begin
          push_item(OPC_LOOKUP, key_pool[$urandom_range(span - 1)]);
        end
        if ($urandom_range(39) == 0) wait_drained();
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
design/ltcc_pkg.sv
design/ltcc_apb_regs.sv
design/ltcc_tag_store.sv
design/ltcc_recency.sv
design/lru_tag_cache_controller_unit.sv
dv/tb_lru_tag_cache_controller_unit.sv
